/* src/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Depends on nothing; imported by text_console_writer.
package tcw_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int COLOR_W    = 8;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0720;

    typedef enum logic [1:0] {
        OP_PUT_CURSOR = 2'd0,
        OP_PUT_AT     = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_SCROLL = 7'b0010000,
        S_FILL   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

endpackage

/* src/text_console_writer.sv */
// Text console writer: screen cell memory, cursor and the sequencer around them.
// Depends on tcw_pkg (types, operation codes, cell constants).
//
// The block holds a COLUMNS x ROWS screen of 16-bit cells (character in the low
// byte, attribute in the high byte) in one memory with a single write port and a
// single registered read port, plus a cursor. One request is taken at a time:
// o_s_tready is high only while the sequencer is idle. A put at the cursor or at
// a position passes through S_EXEC and S_DONE before its result is loaded, a read
// cell through S_EXEC, S_READ and S_DONE (S_READ for the registered memory read).
// With a free output register the sequencer returns to idle as the result is
// loaded, so a new request is taken only once the last one is through.
// A clear screen sweeps every cell through the write port; a newline on the last
// row scrolls, copying every row up through the read and write ports and
// blanking the last row. After reset a clearing pass writes every cell (space,
// color 0x07) before the first request is accepted; the text color register can
// be written meanwhile. A finished result waits in the output register, so the
// next request can be accepted while it is not taken.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // text color register write
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] char_code, [15:8] attribute, [16] use_own_attribute,
    // [23:17] column_in, [28:24] row_in, [31:29] zero
    input  logic [tcw_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [1:0] operation
    input  logic [tcw_pkg::IN_USER_W-1:0]   i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [15:0] read_entry, [22:16] cursor_column, [27:23] cursor_row,
    // [28] scrolled, [31:29] zero
    output logic [tcw_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int MOVE  = CELLS - COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    // Control state
    t_state               r_state,     n_state;
    logic [IW-1:0]        r_idx,       n_idx;
    logic                 r_wr_pend,   n_wr_pend;
    logic [CW-1:0]        r_cur_x,     n_cur_x;
    logic [RW-1:0]        r_cur_y,     n_cur_y;
    logic [AW-1:0]        r_cur_base,  n_cur_base;
    logic                 r_out_valid, n_out_valid;
    logic [COLOR_W-1:0]   r_text_color, n_text_color;

    // Payload
    t_op                  r_op,        n_op;
    logic [CHAR_W-1:0]    r_char,      n_char;
    logic [COLOR_W-1:0]   r_attr,      n_attr;
    logic                 r_in_screen, n_in_screen;
    logic [AW-1:0]        r_addr,      n_addr;
    logic [AW-1:0]        r_wr_addr,   n_wr_addr;
    logic [CELL_W-1:0]    r_entry,     n_entry;
    logic                 r_scrolled,  n_scrolled;
    logic [CELL_W-1:0]    r_fill,      n_fill;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Screen memory
    logic [CELL_W-1:0]    r_screen [CELLS];
    logic [CELL_W-1:0]    r_rd_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [CELL_W-1:0]    mem_wdata;

    // Request fields
    logic [CHAR_W-1:0]    in_char;
    logic [COLOR_W-1:0]   in_attr;
    logic                 in_own;
    logic [6:0]           in_col;
    logic [4:0]           in_row;
    logic                 in_screen;
    logic [IW-1:0]        scroll_src;
    logic                 last_col;
    logic                 last_row;

    assign in_char   = i_s_tdata[7:0];
    assign in_attr   = i_s_tdata[15:8];
    assign in_own    = i_s_tdata[16];
    assign in_col    = i_s_tdata[23:17];
    assign in_row    = i_s_tdata[28:24];
    assign in_screen = (32'(in_col) < COLUMNS) && (32'(in_row) < ROWS);

    assign scroll_src = r_idx + IW'(COLUMNS);
    assign last_col   = (32'(r_cur_x) == COLUMNS - 1);
    assign last_row   = (32'(r_cur_y) == ROWS - 1);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_wr_pend    = r_wr_pend;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_cur_base   = r_cur_base;
        n_out_valid  = r_out_valid;
        n_text_color = r_text_color;
        n_op         = r_op;
        n_char       = r_char;
        n_attr       = r_attr;
        n_in_screen  = r_in_screen;
        n_addr       = r_addr;
        n_wr_addr    = r_wr_addr;
        n_entry      = r_entry;
        n_scrolled   = r_scrolled;
        n_fill       = r_fill;
        n_out_data   = r_out_data;

        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {r_attr, r_char};
        mem_raddr = r_addr;

        // The user writes configuration only while idle; not enforced, taken whenever it comes.
        if (i_cfg_we) begin
            n_text_color = i_cfg_wdata;
        end

        // Drop the held result once the sink takes it.
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    // Latch the request; resolve attribute and cell address now.
                    n_op        = t_op'(i_s_tuser);
                    n_char      = in_char;
                    n_attr      = in_own ? in_attr : r_text_color;
                    n_in_screen = in_screen;
                    n_addr      = AW'(32'(in_row) * COLUMNS + 32'(in_col));
                    n_state     = S_EXEC;
                end
            end

            S_INIT: begin
                // Clearing pass after reset: one cell per cycle.
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = RESET_CELL;
                if (r_idx == IW'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_EXEC: begin
                n_entry    = '0;
                n_scrolled = 1'b0;
                n_state    = S_DONE;
                unique case (r_op)
                    OP_PUT_CURSOR: begin
                        if (r_char == NEWLINE_CODE) begin
                            n_cur_x = '0;
                            if (last_row) begin
                                // Bottom row: scroll the screen instead of moving down.
                                n_idx      = '0;
                                n_wr_pend  = 1'b0;
                                n_scrolled = 1'b1;
                                n_fill     = {r_text_color, SPACE_CODE};
                                n_state    = S_SCROLL;
                            end else begin
                                n_cur_y    = r_cur_y + RW'(1);
                                n_cur_base = r_cur_base + AW'(COLUMNS);
                            end
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_cur_base + AW'(r_cur_x);
                            if (last_col) begin
                                n_cur_x = '0;
                                if (last_row) begin
                                    n_cur_y    = '0;
                                    n_cur_base = '0;
                                end else begin
                                    n_cur_y    = r_cur_y + RW'(1);
                                    n_cur_base = r_cur_base + AW'(COLUMNS);
                                end
                            end else begin
                                n_cur_x = r_cur_x + CW'(1);
                            end
                        end
                    end
                    OP_PUT_AT: begin
                        mem_we = r_in_screen;
                    end
                    OP_CLEAR: begin
                        n_idx      = '0;
                        n_fill     = {r_text_color, SPACE_CODE};
                        n_cur_x    = '0;
                        n_cur_y    = '0;
                        n_cur_base = '0;
                        n_state    = S_FILL;
                    end
                    OP_READ: begin
                        // Read address is r_addr; data lands in r_rd_data next cycle.
                        n_state = S_READ;
                    end
                    default: n_state = S_DONE;
                endcase
            end

            S_READ: begin
                n_entry = r_in_screen ? r_rd_data : '0;
                n_state = S_DONE;
            end

            S_SCROLL: begin
                // Read one row below, write the word read last cycle one row up.
                mem_raddr = scroll_src[AW-1:0];
                mem_we    = r_wr_pend;
                mem_waddr = r_wr_addr;
                mem_wdata = r_rd_data;
                if (r_idx == IW'(MOVE)) begin
                    n_wr_pend = 1'b0;
                    n_state   = S_FILL;
                end else begin
                    n_wr_pend = 1'b1;
                    n_wr_addr = r_idx[AW-1:0];
                    n_idx     = r_idx + IW'(1);
                end
            end

            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_fill;
                if (r_idx == IW'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_scrolled, OUT_ROW_W'(r_cur_y),
                                   OUT_COL_W'(r_cur_x), r_entry};
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_idx        <= '0;
            r_wr_pend    <= 1'b0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_cur_base   <= '0;
            r_out_valid  <= 1'b0;
            r_text_color <= RESET_COLOR;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_wr_pend    <= n_wr_pend;
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_cur_base   <= n_cur_base;
            r_out_valid  <= n_out_valid;
            r_text_color <= n_text_color;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_char      <= n_char;
        r_attr      <= n_attr;
        r_in_screen <= n_in_screen;
        r_addr      <= n_addr;
        r_wr_addr   <= n_wr_addr;
        r_entry     <= n_entry;
        r_scrolled  <= n_scrolled;
        r_fill      <= n_fill;
        r_out_data  <= n_out_data;
    end

    // Screen memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_screen[mem_raddr];
    end

    // Cursor stays on the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_x) < COLUMNS) && (32'(r_cur_y) < ROWS))
        else $error("cursor left the screen");

    // Row base tracks the cursor row.
    a_cursor_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_base == AW'(32'(r_cur_y) * COLUMNS))
        else $error("cursor row base out of step with cursor row");

    // No memory write while waiting for a request.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("screen written while idle");

    // A scroll result leaves the cursor at the start of the last row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_state == S_DONE && r_state == S_FILL && r_scrolled) |->
        (r_cur_x == '0) && last_row)
        else $error("scroll finished with cursor off the last row start");

    // A request accepted moves the sequencer to execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

endmodule
